### hw/rtl/prdg_pkg.sv
package prdg_pkg;

  // Fixed field widths
  localparam int IDX_W  = 12;              // pixel row / column
  localparam int DIM_W  = 13;              // image width / height registers
  localparam int TAN_W  = 16;              // Q4.12 tangents
  localparam int AX_W   = 16;              // Q1.14 axis component
  localparam int VEC_W  = 3 * AX_W;        // packed axis register
  localparam int OUT_W  = 16;              // Q1.x direction component
  localparam int INT_FRAC = 24;            // fraction bits of alpha/beta

  // alpha/beta path
  localparam int MAG_W  = DIM_W;                      // |2*idx+1-dim|
  localparam int PN_W   = MAG_W + TAN_W + (INT_FRAC - 12) + 1; // rounded dividend
  localparam int HALF_W = PN_W / 2;                   // split for partial products
  localparam int PP_W   = HALF_W + 1 + AX_W + 1;      // one partial product

  // direction component path
  localparam int CW     = 61;              // signed component
  localparam int MW     = CW - 1;          // component magnitude
  localparam int NRM_W  = 30;              // normalized magnitude width
  localparam int NRM_ST = 6;               // shift stages 32,16,8,4,2,1
  localparam int SQ_W   = 2 * NRM_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int RT_W   = SUM_W / 2;       // integer square root width
  localparam int RT_ST  = RT_W;            // one result bit per stage

  // configuration
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 6;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_TAN_X        = 3'd2,
    REG_TAN_Y        = 3'd3,
    REG_RIGHT_AXIS   = 3'd4,
    REG_UP_AXIS      = 3'd5,
    REG_BACK_AXIS    = 3'd6
  } reg_idx_t;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);
  localparam logic [TAN_W-1:0] TAN_RST    = TAN_W'(4096);
  localparam logic [VEC_W-1:0] RIGHT_RST  = {16'sd16384, 16'sd0, 16'sd0};
  localparam logic [VEC_W-1:0] UP_RST     = {16'sd0, 16'sd16384, 16'sd0};
  localparam logic [VEC_W-1:0] BACK_RST   = {16'sd0, 16'sd0, 16'sd16384};

endpackage

### hw/rtl/primary_ray_direction_generator.sv
// Throughput: one pixel per cycle while in_tready is high; the two serial dividers
//   and the square-root unit are fully pipelined, one quotient or root bit per stage.
// A two-entry output queue takes results while the sink stalls; in_tready drops
//   only when it is full, and the whole pipe holds in place.
// Reset (rst_n low, synchronous) clears all stage valid bits and the output queue,
//   and loads the camera registers with their power-on values.
module primary_ray_direction_generator
  import prdg_pkg::*;
#(
  parameter int MAX_DIM       = 4096,
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,      // [11:0] pixel_row, [23:12] pixel_col
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,     // [15:0] dir_x, [31:16] dir_y, [47:32] dir_z
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int QB   = DIR_FRAC_BITS + 1;          // quotient bits of final divide
  localparam int NUMW = NRM_W + DIR_FRAC_BITS + 1;  // final dividend width
  localparam int RMW  = RT_W;                       // final divider remainder
  localparam int LAT  = 2 + PN_W + 4 + NRM_ST + 2 + RT_ST + 1 + QB;
  localparam logic [QB-1:0] CAP =
    (DIR_FRAC_BITS >= 15) ? QB'(32767) : QB'(64'd1 << DIR_FRAC_BITS);

  // ---------------------------------------------------------------------------
  // Camera registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] width_r, height_r;
  logic [TAN_W-1:0] tan_x_r, tan_y_r;
  logic [VEC_W-1:0] right_r, up_r, back_r;
  reg_idx_t         cfg_idx;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:3]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      tan_x_r  <= TAN_RST;
      tan_y_r  <= TAN_RST;
      right_r  <= RIGHT_RST;
      up_r     <= UP_RST;
      back_r   <= BACK_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:  width_r  <= cfg_pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_pwdata[DIM_W-1:0];
        REG_TAN_X:        tan_x_r  <= cfg_pwdata[TAN_W-1:0];
        REG_TAN_Y:        tan_y_r  <= cfg_pwdata[TAN_W-1:0];
        REG_RIGHT_AXIS:   right_r  <= cfg_pwdata[VEC_W-1:0];
        REG_UP_AXIS:      up_r     <= cfg_pwdata[VEC_W-1:0];
        REG_BACK_AXIS:    back_r   <= cfg_pwdata[VEC_W-1:0];
        default: ;        // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_idx)
      REG_IMAGE_WIDTH:  cfg_prdata = CFG_DW'(width_r);
      REG_IMAGE_HEIGHT: cfg_prdata = CFG_DW'(height_r);
      REG_TAN_X:        cfg_prdata = CFG_DW'(tan_x_r);
      REG_TAN_Y:        cfg_prdata = CFG_DW'(tan_y_r);
      REG_RIGHT_AXIS:   cfg_prdata = CFG_DW'(right_r);
      REG_UP_AXIS:      cfg_prdata = CFG_DW'(up_r);
      REG_BACK_AXIS:    cfg_prdata = CFG_DW'(back_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // Clamp dimensions: zero reads as one, oversize as MAX_DIM.
  logic [DIM_W-1:0] dim_c [0:1];   // 0: width (column), 1: height (row)
  logic [TAN_W-1:0] tan_c [0:1];
  always_comb begin
    dim_c[0] = (width_r == '0) ? DIM_W'(1) :
               (32'(width_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : width_r;
    dim_c[1] = (height_r == '0) ? DIM_W'(1) :
               (32'(height_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : height_r;
    tan_c[0] = tan_x_r;
    tan_c[1] = tan_y_r;
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: every stage advances together; valid bits ride along.
  // ---------------------------------------------------------------------------
  logic           en;
  logic [LAT-1:0] v_r;
  logic [1:0]     cnt_r;

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_tvalid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: signed pixel-centre numerators 2*idx+1-dim
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] idx_in [0:1];
  logic             s0_neg_r [0:1];
  logic [MAG_W-1:0] s0_mag_r [0:1];

  assign idx_in[0] = in_tdata[23:12];
  assign idx_in[1] = in_tdata[11:0];

  for (genvar a = 0; a < 2; a++) begin : g_num
    logic [MAG_W:0] num;
    assign num = {1'b0, idx_in[a], 1'b1} - {1'b0, dim_c[a]};
    always_ff @(posedge clk) begin
      if (en) begin
        s0_neg_r[a] <= num[MAG_W];
        s0_mag_r[a] <= num[MAG_W] ? MAG_W'(-num) : num[MAG_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 + divider: |num|*tan*2^12 + dim/2, then divide by dim, one bit a stage
  // ---------------------------------------------------------------------------
  logic [PN_W-1:0]  dv_sh_r  [0:PN_W][0:1];
  logic [DIM_W-1:0] dv_rem_r [0:PN_W][0:1];
  logic             dv_neg_r [0:PN_W][0:1];

  for (genvar a = 0; a < 2; a++) begin : g_pn
    logic [MAG_W+TAN_W-1:0] prod;
    assign prod = s0_mag_r[a] * tan_c[a];
    always_ff @(posedge clk) begin
      if (en) begin
        dv_sh_r[0][a]  <= PN_W'({prod, 12'd0}) + PN_W'(dim_c[a] >> 1);
        dv_rem_r[0][a] <= '0;
        dv_neg_r[0][a] <= s0_neg_r[a];
      end
    end
  end

  for (genvar i = 0; i < PN_W; i++) begin : g_dva
    for (genvar a = 0; a < 2; a++) begin : g_lane
      logic [DIM_W:0] t;
      logic           ge;
      assign t  = {dv_rem_r[i][a], dv_sh_r[i][a][PN_W-1]};
      assign ge = (t >= {1'b0, dim_c[a]});
      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem_r[i+1][a] <= ge ? DIM_W'(t - {1'b0, dim_c[a]}) : t[DIM_W-1:0];
          dv_sh_r[i+1][a]  <= {dv_sh_r[i][a][PN_W-2:0], ge};
          dv_neg_r[i+1][a] <= dv_neg_r[i][a];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply: alpha*right and beta*up as two half-width partial products each.
  // The sign of alpha/beta is folded into the axis component.
  // ---------------------------------------------------------------------------
  logic signed [PP_W-1:0] pp_r [0:2][0:3];   // alpha lo, alpha hi, beta lo, beta hi
  logic signed [AX_W-1:0] back_c [0:2];

  for (genvar k = 0; k < 3; k++) begin : g_mul
    logic signed [AX_W-1:0] ax_r, ax_u;
    logic signed [AX_W:0]   ef_r, ef_u;
    logic [PN_W-1:0]        qa, qb;
    assign ax_r      = $signed(right_r[VEC_W-1-AX_W*k -: AX_W]);
    assign ax_u      = $signed(up_r[VEC_W-1-AX_W*k -: AX_W]);
    assign back_c[k] = $signed(back_r[VEC_W-1-AX_W*k -: AX_W]);
    assign ef_r = dv_neg_r[PN_W][0] ? -(AX_W+1)'(ax_r) : (AX_W+1)'(ax_r);
    assign ef_u = dv_neg_r[PN_W][1] ? -(AX_W+1)'(ax_u) : (AX_W+1)'(ax_u);
    assign qa   = dv_sh_r[PN_W][0];
    assign qb   = dv_sh_r[PN_W][1];
    always_ff @(posedge clk) begin
      if (en) begin
        pp_r[k][0] <= $signed({1'b0, qa[HALF_W-1:0]}) * ef_r;
        pp_r[k][1] <= $signed({1'b0, qa[PN_W-1:HALF_W]}) * ef_r;
        pp_r[k][2] <= $signed({1'b0, qb[HALF_W-1:0]}) * ef_u;
        pp_r[k][3] <= $signed({1'b0, qb[PN_W-1:HALF_W]}) * ef_u;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Combine: terms, component sum minus back*2^24, then sign and magnitude
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] ta_r [0:2], tb_r [0:2], c_r [0:2];
  logic [MW-1:0]        nm_r  [0:NRM_ST][0:2];
  logic                 ng_r  [0:NRM_ST][0:2];

  for (genvar k = 0; k < 3; k++) begin : g_sum
    always_ff @(posedge clk) begin
      if (en) begin
        ta_r[k] <= (CW'(pp_r[k][1]) <<< HALF_W) + CW'(pp_r[k][0]);
        tb_r[k] <= (CW'(pp_r[k][3]) <<< HALF_W) + CW'(pp_r[k][2]);
        c_r[k]  <= ta_r[k] + tb_r[k] - (CW'(back_c[k]) <<< INT_FRAC);
        ng_r[0][k] <= c_r[k][CW-1];
        nm_r[0][k] <= c_r[k][CW-1] ? MW'(-c_r[k]) : MW'(c_r[k]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Normalize: shift all three left by one common amount until the leading one
  // of the largest sits at the top bit; a stage per binary shift weight.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < NRM_ST; i++) begin : g_nrm
    localparam int SH = 32 >> i;
    logic [MW-1:0] orv;
    logic          sh;
    assign orv = nm_r[i][0] | nm_r[i][1] | nm_r[i][2];
    assign sh  = (orv[MW-1 -: SH] == '0);
    for (genvar k = 0; k < 3; k++) begin : g_lane
      always_ff @(posedge clk) begin
        if (en) begin
          nm_r[i+1][k] <= sh ? (nm_r[i][k] << SH) : nm_r[i][k];
          ng_r[i+1][k] <= ng_r[i][k];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Squares, their sum, then integer square root one result bit per stage
  // ---------------------------------------------------------------------------
  logic [NRM_W-1:0] sq_m_r [0:2];
  logic             sq_n_r [0:2];
  logic [SQ_W-1:0]  sq_r   [0:2];

  for (genvar k = 0; k < 3; k++) begin : g_sq
    logic [NRM_W-1:0] m;
    assign m = nm_r[NRM_ST][k][MW-1 -: NRM_W];
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k]   <= m * m;
        sq_m_r[k] <= m;
        sq_n_r[k] <= ng_r[NRM_ST][k];
      end
    end
  end

  logic [SUM_W-1:0] rt_s_r   [0:RT_ST];
  logic [SUM_W-1:0] rt_res_r [0:RT_ST];
  logic [NRM_W-1:0] rt_m_r   [0:RT_ST][0:2];
  logic             rt_n_r   [0:RT_ST][0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      rt_s_r[0]   <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
      rt_res_r[0] <= '0;
      rt_m_r[0]   <= sq_m_r;
      rt_n_r[0]   <= sq_n_r;
    end
  end

  for (genvar j = 0; j < RT_ST; j++) begin : g_rt
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * j);
    logic [SUM_W-1:0] trial;
    logic             ge;
    assign trial = rt_res_r[j] + BIT;
    assign ge    = (rt_s_r[j] >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rt_s_r[j+1]   <= ge ? rt_s_r[j] - trial : rt_s_r[j];
        rt_res_r[j+1] <= ge ? (rt_res_r[j] >> 1) + BIT : (rt_res_r[j] >> 1);
        rt_m_r[j+1]   <= rt_m_r[j];
        rt_n_r[j+1]   <= rt_n_r[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Final divide: (mag*2^F + r/2) / r for each component, one bit a stage
  // ---------------------------------------------------------------------------
  logic [RT_W-1:0] r_c;
  logic [RMW-1:0]  fd_rem_r [0:QB][0:2];
  logic [QB-1:0]   fd_sh_r  [0:QB][0:2];
  logic            fd_n_r   [0:QB][0:2];
  logic [RT_W-1:0] fd_r_r   [0:QB];

  assign r_c = rt_res_r[RT_ST][RT_W-1:0];

  for (genvar k = 0; k < 3; k++) begin : g_fd0
    logic [NUMW-1:0] num;
    assign num = (NUMW'(rt_m_r[RT_ST][k]) << DIR_FRAC_BITS) + NUMW'(r_c >> 1);
    always_ff @(posedge clk) begin
      if (en) begin
        fd_rem_r[0][k] <= RMW'(num[NUMW-1:QB]);
        fd_sh_r[0][k]  <= num[QB-1:0];
        fd_n_r[0][k]   <= rt_n_r[RT_ST][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fd_r_r[0] <= r_c;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_fd
    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [RMW:0] t;
      logic         ge;
      assign t  = {fd_rem_r[i][k], fd_sh_r[i][k][QB-1]};
      assign ge = (t >= (RMW+1)'(fd_r_r[i]));
      always_ff @(posedge clk) begin
        if (en) begin
          fd_rem_r[i+1][k] <= ge ? RMW'(t - (RMW+1)'(fd_r_r[i])) : t[RMW-1:0];
          if (QB > 1) begin
            fd_sh_r[i+1][k] <= {fd_sh_r[i][k][QB-2:0], ge};
          end else begin
            fd_sh_r[i+1][k] <= QB'(ge);
          end
          fd_n_r[i+1][k] <= fd_n_r[i][k];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        fd_r_r[i+1] <= fd_r_r[i];
      end
    end
  end

  // Clamp, apply sign; an all-zero direction gives r == 0 and reads as zero.
  logic [47:0] res_c;
  for (genvar k = 0; k < 3; k++) begin : g_out
    logic [QB-1:0]    qc;
    logic [OUT_W-1:0] mag;
    assign qc  = (fd_sh_r[QB][k] > CAP) ? CAP : fd_sh_r[QB][k];
    assign mag = OUT_W'(qc);
    assign res_c[OUT_W*k +: OUT_W] = (fd_r_r[QB] == '0) ? '0 :
                                     fd_n_r[QB][k] ? -mag : mag;
  end

  // ---------------------------------------------------------------------------
  // Output queue: two entries so the pipe keeps moving while one result waits
  // ---------------------------------------------------------------------------
  logic [47:0] oq_r [0:1];
  logic        wp_r, rp_r;
  logic        push, pop;

  assign push       = en && v_r[LAT-1];
  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = oq_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      oq_r[wp_r] <= res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("output queue overflow");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && cnt_r == 2'd2))
    else $error("input stalled without a full output queue");

  a_rst_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_tvalid)
    else $error("result visible right after reset");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ($signed(res_c[15:0]) <= $signed(17'(CAP)) &&
              $signed(res_c[31:16]) <= $signed(17'(CAP)) &&
              $signed(res_c[47:32]) <= $signed(17'(CAP))))
    else $error("direction component above cap");

endmodule
